// ===== sv/rbrc_pkg.sv =====
// shared types and constants of the receive buffer ring consumer
`timescale 1ns / 1ps
`default_nettype none
package rbrc_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int DATA_W         = 16;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int CFG_IDX_W      = 2;

    localparam logic [DATA_W-1:0] BUF_SIZE_RESET = 16'd4096;
    localparam logic [CNT_W-1:0]  BUF_COUNT_RESET = 7'd64;
    localparam logic [DATA_W-1:0] SCRATCH_RESET  = 16'd8192;
    localparam logic [DATA_W-1:0] RESIDUAL_RESET = 16'd4096;

    localparam logic [1:0] REQ_FILL    = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_RECYCLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH_CAP  = 2'd2;

    typedef enum logic [2:0] {
        STAT_NO_DATA  = 3'd0,
        STAT_DATA     = 3'd1,
        STAT_STRADDLE = 3'd2,
        STAT_RECYCLED = 3'd3,
        STAT_BAD_ARG  = 3'd4,
        STAT_FILLED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_NEXT,
        S_EXEC
    } fsm_t;

    typedef struct packed {
        status_t           status;
        logic              advance;
        logic              to_next;
        logic              auto_recycled;
        logic [DATA_W-1:0] first_offset;
        logic [DATA_W-1:0] bytes_filled;
        logic [DATA_W-1:0] old_tail_length;
        logic [DATA_W-1:0] new_head_length;
        logic [DATA_W-1:0] consumed_next;
    } deq_result_t;

endpackage
`default_nettype wire

// ===== sv/rbrc_dequeue.sv =====
// dequeue decision: straddle, auto recycle and new byte accounting
`timescale 1ns / 1ps
`default_nettype none
module rbrc_dequeue
    import rbrc_pkg::*;
(
    input  wire logic [DATA_W-1:0] req_size,
    input  wire logic [DATA_W-1:0] scratch_cap,
    input  wire logic [DATA_W-1:0] consumed,
    input  wire logic [DATA_W-1:0] next_resid,
    input  wire logic [DATA_W-1:0] head_resid,
    input  wire logic              single_ring,
    output deq_result_t            result
);

    always_comb
    begin
        logic [DATA_W-1:0] tail_bytes;
        logic [DATA_W-1:0] head_bytes;
        logic [DATA_W-1:0] c_old;
        logic [DATA_W-1:0] room;
        logic [DATA_W-1:0] c_new;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] base;
        logic              go_straddle;
        logic              recycle;

        tail_bytes = (req_size > consumed) ? req_size - consumed : '0;
        head_bytes = (req_size > next_resid) ? req_size - next_resid : '0;
        go_straddle = 1'b0;
        recycle = 1'b0;
        // next buffer has data once its residual moved off the full size
        if (next_resid != req_size)
        begin
            if (scratch_cap != '0 && (tail_bytes != '0 || head_bytes != '0))
                go_straddle = 1'b1;
            else
                recycle = 1'b1;
        end
        c_old = (tail_bytes < scratch_cap) ? tail_bytes : scratch_cap;
        room = scratch_cap - c_old;
        c_new = (head_bytes < room) ? head_bytes : room;

        if (recycle)
        begin
            // in a single-buffer ring the next buffer is the head itself: it was just rewritten with the full size
            res = single_ring ? req_size : next_resid;
            base = '0;
        end
        else
        begin
            res = head_resid;
            base = consumed;
        end
        total = (res <= req_size) ? req_size - res : '0;

        result = '0;
        if (go_straddle)
        begin
            result.status = STAT_STRADDLE;
            result.advance = 1'b1;
            result.to_next = 1'b0;
            result.auto_recycled = 1'b1;
            result.bytes_filled = c_old + c_new;
            result.old_tail_length = c_old;
            result.new_head_length = c_new;
            result.consumed_next = c_new;
        end
        else if (total <= base)
        begin
            result.status = STAT_NO_DATA;
            result.advance = recycle;
            result.to_next = recycle;
            result.auto_recycled = recycle;
            result.consumed_next = base;
        end
        else
        begin
            result.status = STAT_DATA;
            result.advance = recycle;
            result.to_next = recycle;
            result.auto_recycled = recycle;
            result.first_offset = base;
            result.bytes_filled = total;
            result.consumed_next = total;
        end
    end

endmodule
`default_nettype wire

// ===== sv/receive_buffer_ring_consumer.sv =====
// top level: residual count memory, head and consumed registers, request sequencer
// fill report, recycle and bad requests: result in the cycle after accept, busy stays low
// dequeue: busy through S_READ_NEXT and S_EXEC, result registered from S_EXEC; one read port reads the
//   head entry, then the next; a head beyond a reduced count stays in S_READ_NEXT for each fold
// results appear for one cycle on done; the receiver cannot stall
// after reset a clearing pass loads every entry in turn with 4096 (busy high)
`timescale 1ns / 1ps
`default_nettype none
module receive_buffer_ring_consumer
    import rbrc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           req_type,
    input  wire logic [IDX_W-1:0]     buffer_index,
    input  wire logic [DATA_W-1:0]    residual_count,
    output logic                      done,
    output logic [2:0]                status,
    output logic [IDX_W-1:0]          result_index,
    output logic [DATA_W-1:0]         first_offset,
    output logic [DATA_W-1:0]         bytes_filled,
    output logic [DATA_W-1:0]         old_tail_length,
    output logic [DATA_W-1:0]         new_head_length,
    output logic                      auto_recycled,
    output logic [IDX_W-1:0]          head_position
);

    localparam int RING_DEPTH = RING_DEPTH_DEF;
    localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

    logic [DATA_W-1:0] mem [RING_DEPTH];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [DATA_W-1:0] buf_size_reg;
    logic [CNT_W-1:0]  buf_count_reg;
    logic [DATA_W-1:0] scratch_reg;

    fsm_t              state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [DATA_W-1:0] cons_reg, cons_next;
    logic [DATA_W-1:0] head_resid_reg;
    logic [CNT_W-1:0]  wrap_reg, wrap_next;

    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [DATA_W-1:0] start_reg, start_next;
    logic [DATA_W-1:0] filled_reg, filled_next;
    logic [DATA_W-1:0] tail_reg, tail_next;
    logic [DATA_W-1:0] nhead_reg, nhead_next;
    logic              auto_reg, auto_next;
    logic [IDX_W-1:0]  hpos_reg, hpos_next;

    logic [CNT_W-1:0]  live_cnt;
    logic [CNT_W-1:0]  head_inc;
    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  deq_next;
    logic              accept;
    logic              idx_in_range;
    deq_result_t       deq;

    // count in use, clamped to 1..RING_DEPTH
    always_comb
    begin
        if (buf_count_reg == '0)
            live_cnt = CNT_W'(1);
        else if (int'(buf_count_reg) > RING_DEPTH)
            live_cnt = CNT_W'(RING_DEPTH);
        else
            live_cnt = buf_count_reg;
    end

    assign head_inc = {1'b0, head_reg} + CNT_W'(1);
    assign next_idx = (head_inc == live_cnt) ? '0 : head_inc[IDX_W-1:0];
    assign deq_next = wrap_reg[IDX_W-1:0];
    assign idx_in_range = ({1'b0, buffer_index} < live_cnt);
    assign busy = (state_reg != S_IDLE);
    assign accept = start && !busy;

    rbrc_dequeue u_dequeue (
        .req_size    (buf_size_reg),
        .scratch_cap (scratch_reg),
        .consumed    (cons_reg),
        .next_resid  (mem_rdata_reg),
        .head_resid  (head_resid_reg),
        .single_ring (deq_next == head_reg),
        .result      (deq)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_size_reg <= BUF_SIZE_RESET;
            buf_count_reg <= BUF_COUNT_RESET;
            scratch_reg <= SCRATCH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BUFFER_SIZE:  buf_size_reg <= cfg_data;
                CFG_BUFFER_COUNT: buf_count_reg <= cfg_data[CNT_W-1:0];
                CFG_SCRATCH_CAP:  scratch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_addr_reg <= '0;
            head_reg <= '0;
            cons_reg <= '0;
            wrap_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            head_reg <= head_next;
            cons_reg <= cons_next;
            wrap_reg <= wrap_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ_NEXT)
            head_resid_reg <= mem_rdata_reg;
        status_reg <= status_next;
        index_reg <= index_next;
        start_reg <= start_next;
        filled_reg <= filled_next;
        tail_reg <= tail_next;
        nhead_reg <= nhead_next;
        auto_reg <= auto_next;
        hpos_reg <= hpos_next;
    end

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        cons_next = cons_reg;
        wrap_next = wrap_reg;
        mem_we = 1'b0;
        mem_waddr = ADDR_W'(head_reg);
        mem_wdata = buf_size_reg;
        mem_re = 1'b0;
        mem_raddr = ADDR_W'(head_reg);
        done_next = 1'b0;
        status_next = STAT_BAD_ARG;
        index_next = buffer_index;
        start_next = '0;
        filled_next = '0;
        tail_next = '0;
        nhead_next = '0;
        auto_next = 1'b0;
        hpos_next = head_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = RESIDUAL_RESET;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (req_type)
                        REQ_FILL:
                        begin
                            if (idx_in_range)
                            begin
                                mem_we = 1'b1;
                                mem_waddr = ADDR_W'(buffer_index);
                                mem_wdata = residual_count;
                                status_next = STAT_FILLED;
                            end
                        end
                        REQ_RECYCLE:
                        begin
                            if (idx_in_range && buffer_index == head_reg)
                            begin
                                mem_we = 1'b1;
                                mem_waddr = ADDR_W'(buffer_index);
                                head_next = next_idx;
                                cons_next = '0;
                                status_next = STAT_RECYCLED;
                                hpos_next = next_idx;
                            end
                        end
                        REQ_DEQUEUE:
                        begin
                            // head entry first, next entry from S_READ_NEXT once the index is folded
                            done_next = 1'b0;
                            mem_re = 1'b1;
                            wrap_next = (head_inc == live_cnt) ? '0 : head_inc;
                            state_next = S_READ_NEXT;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ_NEXT:
            begin
                // head beyond a reduced count: fold the next index back one count at a time
                if (wrap_reg >= live_cnt)
                    wrap_next = wrap_reg - live_cnt;
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = ADDR_W'(deq_next);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                mem_we = deq.advance;
                cons_next = deq.consumed_next;
                if (deq.advance)
                    head_next = deq_next;
                done_next = 1'b1;
                status_next = deq.status;
                index_next = deq.to_next ? deq_next : head_reg;
                start_next = deq.first_offset;
                filled_next = deq.bytes_filled;
                tail_next = deq.old_tail_length;
                nhead_next = deq.new_head_length;
                auto_next = deq.auto_recycled;
                hpos_next = deq.advance ? deq_next : head_reg;
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign status = status_reg;
    assign result_index = index_reg;
    assign first_offset = start_reg;
    assign bytes_filled = filled_reg;
    assign old_tail_length = tail_reg;
    assign new_head_length = nhead_reg;
    assign auto_recycled = auto_reg;
    assign head_position = hpos_reg;

endmodule
`default_nettype wire
